// ===== rtl/cld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and constants of the canonical line discipline unit.
// ----------------------------------------------------------------------------
package cld_pkg;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    K_ECHO = 3'd0,
    K_INTR = 3'd1,
    K_SUSP = 3'd2,
    K_READ = 3'd3,
    K_EOF  = 3'd4,
    K_NONE = 3'd5
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_INTR  = 3'd1;
  localparam logic [2:0] CFG_SUSP  = 3'd2;
  localparam logic [2:0] CFG_EOF   = 3'd3;
  localparam logic [2:0] CFG_ERASE = 3'd4;

  // mode flag bit positions
  localparam int unsigned MODE_ECHO  = 0;
  localparam int unsigned MODE_ECHOE = 1;
  localparam int unsigned MODE_CANON = 2;
  localparam int unsigned MODE_SIGS  = 3;
  localparam int unsigned MODE_CRLF  = 4;

  localparam logic [4:0] MODE_RST  = 5'd31;
  localparam logic [4:0] INTR_RST  = 5'd3;
  localparam logic [4:0] SUSP_RST  = 5'd26;
  localparam logic [4:0] EOF_RST   = 5'd4;
  localparam logic [7:0] ERASE_RST = 8'd127;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  // one accepted item's results, handed from the editor to the sequencer
  typedef struct packed {
    logic       valid;     // item yields at least one result
    kind_e      kind;
    logic [7:0] data;
    logic       erase;     // three-byte erase echo
    logic       from_ram;  // data comes from the line store read
  } desc_t;

endpackage

// ===== rtl/cld_key_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_key_if
// Input channel: key events and read requests.
// ----------------------------------------------------------------------------
interface cld_key_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] key_code;
  logic       is_backspace_key;
  logic       ctrl_held;

  modport source (output valid, operation, key_code, is_backspace_key, ctrl_held,
                  input ready);
  modport sink (input valid, operation, key_code, is_backspace_key, ctrl_held,
                output ready);
endinterface

// ===== rtl/cld_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_res_if
// Output channel: echo bytes, signals, read bytes and status.
// ----------------------------------------------------------------------------
interface cld_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, kind, data_byte, last, input ready);
  modport sink (input valid, kind, data_byte, last, output ready);
endinterface

// ===== rtl/cld_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cld_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cld_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cld_line_ram #(
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cld_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_editor
// Configuration registers, line pointers and per-item decode. Issues the
// line store write or read and hands a result descriptor downstream.
// ----------------------------------------------------------------------------
module cld_editor #(
  parameter int unsigned LineDepth = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cld_key_if.sink                      key_i,
  cld_cfg_if.sink                      cfg_i,
  input  logic                         take_ok_i,
  output cld_pkg::desc_t               desc_o,
  output logic                         ram_we_o,
  output logic [$clog2(LineDepth)-1:0] ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         ram_re_o,
  output logic [$clog2(LineDepth)-1:0] ram_raddr_o
);

  localparam int unsigned AddrW = $clog2(LineDepth);
  localparam int unsigned PtrW  = $clog2(LineDepth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(LineDepth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);

  logic [4:0] mode_q, intr_q, susp_q, eof_q;
  logic [7:0] erase_q;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, rp_inc;
  logic ready_q, ready_d;

  logic       fire;
  logic [4:0] code;
  logic       ctrl_hit, is_intr, is_susp, is_eof, is_erase;
  logic [7:0] ch_m;

  assign key_i.ready = take_ok_i;
  assign cfg_i.ready = 1'b1;
  assign fire        = key_i.valid && take_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cld_pkg::MODE_RST;
      intr_q  <= cld_pkg::INTR_RST;
      susp_q  <= cld_pkg::SUSP_RST;
      eof_q   <= cld_pkg::EOF_RST;
      erase_q <= cld_pkg::ERASE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cld_pkg::CFG_MODE:  mode_q  <= cfg_i.data[4:0];
        cld_pkg::CFG_INTR:  intr_q  <= cfg_i.data[4:0];
        cld_pkg::CFG_SUSP:  susp_q  <= cfg_i.data[4:0];
        cld_pkg::CFG_EOF:   eof_q   <= cfg_i.data[4:0];
        cld_pkg::CFG_ERASE: erase_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign code     = key_i.key_code[4:0];
  assign ctrl_hit = key_i.ctrl_held && (key_i.key_code != cld_pkg::CH_NUL);
  assign is_intr  = ctrl_hit && mode_q[cld_pkg::MODE_SIGS] && (code == intr_q);
  assign is_susp  = ctrl_hit && mode_q[cld_pkg::MODE_SIGS] && !is_intr
                    && (code == susp_q);
  assign is_eof   = ctrl_hit && !is_intr && !is_susp && (code == eof_q);
  assign is_erase = key_i.is_backspace_key || (key_i.key_code == erase_q);
  assign ch_m     = (key_i.key_code == cld_pkg::CH_CR && mode_q[cld_pkg::MODE_CRLF])
                    ? cld_pkg::CH_LF : key_i.key_code;
  assign rp_inc   = rp_q + PtrOne;

  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    ready_d     = ready_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q[AddrW-1:0];
    ram_wdata_o = ch_m;
    ram_re_o    = 1'b0;
    ram_raddr_o = rp_q[AddrW-1:0];
    desc_o      = '0;
    desc_o.kind = cld_pkg::K_ECHO;
    if (fire) begin
      if (key_i.operation == cld_pkg::OP_READ) begin
        desc_o.valid = 1'b1;
        if (!ready_q) begin
          desc_o.kind = cld_pkg::K_NONE;
        end else if (rp_q >= wp_q || rp_q >= PtrMax) begin
          desc_o.kind = cld_pkg::K_EOF;
          wp_d        = '0;
          rp_d        = '0;
          ready_d     = 1'b0;
        end else begin
          desc_o.kind     = cld_pkg::K_READ;
          desc_o.from_ram = 1'b1;
          ram_re_o        = 1'b1;
          rp_d            = rp_inc;
          if (rp_inc >= wp_q) begin
            wp_d    = '0;
            rp_d    = '0;
            ready_d = 1'b0;
          end
        end
      end else if (is_intr) begin
        desc_o.valid = 1'b1;
        desc_o.kind  = cld_pkg::K_INTR;
      end else if (is_susp) begin
        desc_o.valid = 1'b1;
        desc_o.kind  = cld_pkg::K_SUSP;
      end else if (is_eof) begin
        ready_d = 1'b1;
      end else if (is_erase) begin
        if (wp_q != '0) begin
          wp_d         = wp_q - PtrOne;
          desc_o.valid = mode_q[cld_pkg::MODE_ECHOE];
          desc_o.erase = 1'b1;
        end
      end else if (key_i.key_code != cld_pkg::CH_NUL) begin
        desc_o.valid = mode_q[cld_pkg::MODE_ECHO];
        desc_o.data  = ch_m;
        if (wp_q < PtrMax) begin
          ram_we_o = 1'b1;
          wp_d     = wp_q + PtrOne;
        end
        if (mode_q[cld_pkg::MODE_CANON]
            && (ch_m == cld_pkg::CH_LF || ch_m == cld_pkg::CH_CR)) begin
          ready_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      ready_q <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      ready_q <= ready_d;
    end
  end

endmodule

// ===== rtl/cld_result_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_result_seq
// Result sequencer: a stage that waits out the line store read, then an
// output register that plays one item's results out one transfer at a time.
// ----------------------------------------------------------------------------
module cld_result_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cld_pkg::desc_t desc_i,
  input  logic [7:0]     ram_rdata_i,
  output logic           take_ok_o,
  cld_res_if.source      res_o
);

  cld_pkg::desc_t s1_q;
  logic           pend_valid_q;
  cld_pkg::kind_e pend_kind_q;
  logic [7:0]     pend_data_q;
  logic           pend_erase_q;
  logic [1:0]     pend_idx_q;

  logic xfer, pend_done, s1_move;

  assign xfer      = res_o.valid && res_o.ready;
  assign pend_done = xfer && res_o.last;
  assign s1_move   = s1_q.valid && (!pend_valid_q || pend_done);
  assign take_ok_o = !s1_q.valid || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q         <= '0;
      pend_valid_q <= 1'b0;
      pend_kind_q  <= cld_pkg::K_ECHO;
      pend_data_q  <= '0;
      pend_erase_q <= 1'b0;
      pend_idx_q   <= '0;
    end else begin
      if (take_ok_o) begin
        s1_q <= desc_i;
      end
      if (s1_move) begin
        pend_valid_q <= 1'b1;
        pend_kind_q  <= s1_q.kind;
        pend_data_q  <= s1_q.from_ram ? ram_rdata_i : s1_q.data;
        pend_erase_q <= s1_q.erase;
        pend_idx_q   <= '0;
      end else if (pend_done) begin
        pend_valid_q <= 1'b0;
      end else if (xfer) begin
        pend_idx_q <= pend_idx_q + 2'd1;
      end
    end
  end

  // erase echo is backspace, space, backspace
  assign res_o.valid     = pend_valid_q;
  assign res_o.kind      = pend_kind_q;
  assign res_o.data_byte = !pend_erase_q ? pend_data_q
                         : (pend_idx_q == 2'd1) ? cld_pkg::CH_SP : cld_pkg::CH_BS;
  assign res_o.last      = !pend_erase_q || (pend_idx_q == 2'd2);

endmodule

// ===== rtl/canonical_line_discipline_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_line_discipline_unit
// Path: each item's results pass the middle stage register, then the output
// register; an output stall can hold them in either. Throughput: one item per
// cycle while the output does not stall; an erase echo holds the output for
// three transfers, set by the single output register that plays results out.
// Line store read data is registered, and the middle stage covers the read.
// Reset: pointers, line-ready flag and pipeline cleared, registers take their
// reset values; the line store is not cleared.
// ----------------------------------------------------------------------------
module canonical_line_discipline_unit #(
  parameter int unsigned LINE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cld_key_if.sink   key_i,
  cld_cfg_if.sink   cfg_i,
  cld_res_if.source res_o
);

  localparam int unsigned AddrW = $clog2(LINE_DEPTH);

  cld_pkg::desc_t   desc;
  logic             take_ok;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  cld_editor #(
    .LineDepth(LINE_DEPTH)
  ) u_editor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_i),
    .cfg_i      (cfg_i),
    .take_ok_i  (take_ok),
    .desc_o     (desc),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr)
  );

  cld_line_ram #(
    .Depth(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cld_result_seq u_result_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (desc),
    .ram_rdata_i(ram_rdata),
    .take_ok_o  (take_ok),
    .res_o      (res_o)
  );

endmodule

// ===== verif/cld_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_line_checker
// Passive monitor for the line discipline unit. It follows register writes and
// key/read transfers, keeps its own line store, pointers and ready flag, and
// checks every result transfer in order against the predicted kind, byte and
// last flag.
// ----------------------------------------------------------------------------
module cld_line_checker
  import cld_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cld_key_if          key_i,
  cld_cfg_if          cfg_i,
  cld_res_if          res_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } line_res_t;

  logic [7:0]  line_mem [LINE_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  bit          line_rdy;

  logic [4:0]  mode_q;
  logic [4:0]  intr_q;
  logic [4:0]  susp_q;
  logic [4:0]  eof_q;
  logic [7:0]  erase_q;

  line_res_t   results_due[$];
  int unsigned errs;

  function automatic void flush_line();
    wr_ptr   = 0;
    rd_ptr   = 0;
    line_rdy = 1'b0;
  endfunction

  // Applies one key or read item to the line state and queues what it yields.
  function automatic void edit_line(input logic op, input logic [7:0] key_ch,
                                    input logic bksp, input logic ctrl);
    line_res_t  outs[$];
    logic [7:0] ch;
    logic [4:0] code;
    bit         taken;
    ch    = key_ch;
    code  = key_ch[4:0];
    taken = 1'b0;
    if (op == OP_READ) begin
      if (!line_rdy) begin
        outs.push_back('{kind: K_NONE, data: CH_NUL, last: 1'b0});
      end else if (rd_ptr >= wr_ptr) begin
        flush_line();
        outs.push_back('{kind: K_EOF, data: CH_NUL, last: 1'b0});
      end else begin
        outs.push_back('{kind: K_READ, data: line_mem[AW'(rd_ptr)], last: 1'b0});
        rd_ptr++;
        if (rd_ptr >= wr_ptr) flush_line();
      end
    end else begin
      if (ctrl && ch != CH_NUL) begin
        if (mode_q[MODE_SIGS] && code == intr_q) begin
          outs.push_back('{kind: K_INTR, data: CH_NUL, last: 1'b0});
          taken = 1'b1;
        end else if (mode_q[MODE_SIGS] && code == susp_q) begin
          outs.push_back('{kind: K_SUSP, data: CH_NUL, last: 1'b0});
          taken = 1'b1;
        end else if (code == eof_q) begin
          line_rdy = 1'b1;
          taken    = 1'b1;
        end
      end
      if (!taken) begin
        if (bksp || ch == erase_q) begin
          if (wr_ptr != 0) begin
            wr_ptr--;
            if (mode_q[MODE_ECHOE]) begin
              outs.push_back('{kind: K_ECHO, data: CH_BS, last: 1'b0});
              outs.push_back('{kind: K_ECHO, data: CH_SP, last: 1'b0});
              outs.push_back('{kind: K_ECHO, data: CH_BS, last: 1'b0});
            end
          end
        end else if (ch != CH_NUL) begin
          if (ch == CH_CR && mode_q[MODE_CRLF]) ch = CH_LF;
          if (mode_q[MODE_ECHO]) outs.push_back('{kind: K_ECHO, data: ch, last: 1'b0});
          // a full store still echoes and may still end the line
          if (wr_ptr < LINE_DEPTH) begin
            line_mem[AW'(wr_ptr)] = ch;
            wr_ptr++;
          end
          if (mode_q[MODE_CANON] && (ch == CH_LF || ch == CH_CR)) line_rdy = 1'b1;
        end
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) results_due.push_back(outs[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    line_res_t want;
    if (!rst_ni) begin
      mode_q  = MODE_RST;
      intr_q  = INTR_RST;
      susp_q  = SUSP_RST;
      eof_q   = EOF_RST;
      erase_q = ERASE_RST;
      flush_line();
      results_due.delete();
      errs = 0;
    end else begin
      // results never belong to an item accepted at the same edge
      if (res_i.valid && res_i.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d, data_byte %02h, last %0b",
                 res_i.kind, res_i.data_byte, res_i.last);
          errs++;
        end else begin
          want = results_due.pop_front();
          if (res_i.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, res_i.kind);
            errs++;
          end
          if (res_i.data_byte !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, res_i.data_byte);
            errs++;
          end
          if (res_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_i.last);
            errs++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MODE:  mode_q  = cfg_i.data[4:0];
          CFG_INTR:  intr_q  = cfg_i.data[4:0];
          CFG_SUSP:  susp_q  = cfg_i.data[4:0];
          CFG_EOF:   eof_q   = cfg_i.data[4:0];
          CFG_ERASE: erase_q = cfg_i.data;
          default: ;
        endcase
      end
      if (key_i.valid && key_i.ready) begin
        edit_line(key_i.operation, key_i.key_code, key_i.is_backspace_key, key_i.ctrl_held);
      end
    end
    error_count_o <= errs;
    pending_o     <= results_due.size();
  end

endmodule

// ===== verif/tb_canonical_line_discipline_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_line_discipline_unit
// Drives key events, read requests and register writes into the line
// discipline unit with random gaps and output stalls. A short directed
// sequence is followed by random line sessions under several register
// settings and a line that overruns the store; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_canonical_line_discipline_unit;
  import cld_pkg::*;

  localparam int unsigned LINE_DEPTH     = 256;
  localparam int unsigned RANDOM_ITEMS   = 160;
  localparam int unsigned PHASE_ITEMS    = 60;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;

  cld_key_if key_ch ();
  cld_cfg_if cfg_ch ();
  cld_res_if res_ch ();

  int unsigned chk_errors;
  int unsigned chk_pending;

  int unsigned items_sent    = 0;
  int unsigned settings_used = 1;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;
  bit          hold_req      = 1'b0;

  logic [4:0] cur_intr  = INTR_RST;
  logic [4:0] cur_susp  = SUSP_RST;
  logic [4:0] cur_eof   = EOF_RST;
  logic [7:0] cur_erase = ERASE_RST;

  canonical_line_discipline_unit #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (key_ch),
    .cfg_i (cfg_ch),
    .res_o (res_ch)
  );

  cld_line_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_ch),
    .cfg_i        (cfg_ch),
    .res_i        (res_ch),
    .error_count_o(chk_errors),
    .pending_o    (chk_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic key_pause(input int unsigned n);
    key_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(input op_e op, input logic [7:0] ch, input logic bksp,
                           input logic ctrl);
    key_ch.valid            <= 1'b1;
    key_ch.operation        <= op;
    key_ch.key_code         <= ch;
    key_ch.is_backspace_key <= bksp;
    key_ch.ctrl_held        <= ctrl;
    @(posedge clk_i);
    while (!key_ch.ready) @(posedge clk_i);
    items_sent++;
    if (!tx_steady && $urandom_range(0, 3) == 0) key_pause(gap_cycles());
  endtask

  task automatic send_read();
    send_item(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_results_drained();
    key_pause(1);
    while (chk_pending != 0) @(posedge clk_i);
    // items that yield nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // upper bits of the 5-bit registers carry junk that must be ignored
  task automatic program_regs(input logic [4:0] mode, input logic [4:0] intr,
                              input logic [4:0] susp, input logic [4:0] eof,
                              input logic [7:0] erase);
    write_reg(CFG_MODE,  {3'($urandom), mode});
    write_reg(CFG_INTR,  {3'($urandom), intr});
    write_reg(CFG_SUSP,  {3'($urandom), susp});
    write_reg(CFG_EOF,   {3'($urandom), eof});
    write_reg(CFG_ERASE, erase);
    cfg_ch.valid <= 1'b0;
    cur_intr  = intr;
    cur_susp  = susp;
    cur_eof   = eof;
    cur_erase = erase;
    settings_used++;
  endtask

  // typed line with edits and control keys, an optional terminator, then reads past its end
  task automatic line_session();
    int unsigned len;
    int unsigned sel;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        send_item(op_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (sel == 1) begin
        send_item(OP_KEY, 8'($urandom), 1'b1, 1'($urandom));
      end else if (sel == 2) begin
        send_item(OP_KEY, cur_erase, 1'b0, 1'b0);
      end else if (sel == 3) begin
        send_item(OP_KEY, {3'($urandom), ($urandom_range(0, 1) ? cur_intr : cur_susp)},
                  1'b0, 1'b1);
      end else if (sel == 4) begin
        send_item(OP_KEY, 8'($urandom), 1'b0, 1'b1);
      end else begin
        send_item(OP_KEY, 8'($urandom_range(1, 255)), 1'b0, 1'b0);
      end
    end
    sel = $urandom_range(0, 5);
    case (sel)
      0, 1:    send_item(OP_KEY, CH_CR, 1'b0, 1'b0);
      2:       send_item(OP_KEY, CH_LF, 1'b0, 1'b0);
      3, 4:    send_item(OP_KEY, {3'($urandom), cur_eof}, 1'b0, 1'b1);
      default: ;
    endcase
    repeat (len + $urandom_range(1, 2)) send_read();
  endtask

  // output side: random stalls, steady stretches and one requested long hold
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b0;
        repeat (gap_cycles()) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_canonical_line_discipline_unit NOT OK");
    $finish;
  end

  initial begin
    int unsigned next_switch;
    int unsigned phase_no;
    bit          hold_done;
    key_ch.valid            <= 1'b0;
    key_ch.operation        <= OP_KEY;
    key_ch.key_code         <= CH_NUL;
    key_ch.is_backspace_key <= 1'b0;
    key_ch.ctrl_held        <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= CFG_MODE;
    cfg_ch.data             <= 8'h00;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed, reset register values
    send_read();                                // nothing ready yet
    send_item(OP_KEY, CH_NUL, 1'b0, 1'b0);      // non-printable key
    send_item(OP_KEY, CH_NUL, 1'b1, 1'b0);      // backspace on empty store
    send_item(OP_KEY, 8'h63, 1'b0, 1'b1);       // ^C interrupt
    send_item(OP_KEY, 8'h7A, 1'b0, 1'b1);       // ^Z suspend
    send_item(OP_KEY, 8'h41, 1'b0, 1'b0);
    send_item(OP_KEY, 8'hFF, 1'b0, 1'b0);
    send_item(OP_KEY, 8'h01, 1'b0, 1'b0);
    send_item(OP_KEY, CH_NUL, 1'b1, 1'b0);      // backspace key
    send_item(OP_KEY, ERASE_RST, 1'b0, 1'b0);   // erase char
    send_item(OP_KEY, CH_CR, 1'b0, 1'b0);       // CR mapped to LF, line ready
    send_read();
    send_read();
    send_read();
    send_item(OP_KEY, 8'h64, 1'b0, 1'b1);       // ^D on empty line
    send_read();
    send_item(OP_KEY, 8'h78, 1'b0, 1'b0);
    send_item(OP_KEY, 8'h44, 1'b0, 1'b1);       // ^D with upper bits set
    send_item(OP_KEY, CH_NUL, 1'b1, 1'b0);      // erase after ready
    send_read();
    send_item(OP_KEY, 8'h71, 1'b0, 1'b1);       // ctrl with no match falls through
    send_item(OP_KEY, 8'h62, 1'b0, 1'b0);
    send_item(OP_KEY, CH_LF, 1'b0, 1'b0);
    send_read();
    send_item(OP_KEY, CH_NUL, 1'b1, 1'b0);
    send_item(OP_KEY, CH_NUL, 1'b1, 1'b0);      // ready line shrunk to the read point
    send_read();

    // random line sessions under changing register settings
    next_switch = items_sent;
    phase_no    = 0;
    hold_done   = 1'b0;
    while (items_sent < 25 + RANDOM_ITEMS) begin
      if (items_sent >= next_switch) begin
        wait_results_drained();
        case (phase_no)
          0:       program_regs(5'd0, 5'd0, 5'd0, 5'd0, 8'h00);
          1:       program_regs(5'd31, 5'd31, 5'd31, 5'd31, 8'hFF);
          default: program_regs(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                                8'($urandom));
        endcase
        phase_no++;
        next_switch = items_sent + PHASE_ITEMS;
      end
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (!hold_done && items_sent > 100) begin
        // stall the output while input keeps coming so the pipeline backs up
        hold_done = 1'b1;
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        hold_req  = 1'b1;
      end
      line_session();
    end

    // overrun the line store, end the line, then read the head of it back
    wait_results_drained();
    program_regs(MODE_RST, INTR_RST, SUSP_RST, EOF_RST, ERASE_RST);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (LINE_DEPTH + 2) send_item(OP_KEY, 8'($urandom_range(8'h21, 8'h7E)), 1'b0, 1'b0);
    send_item(OP_KEY, CH_CR, 1'b0, 1'b0);
    repeat (4) send_read();

    wait_results_drained();
    $display("covered %0d key/read transfers over %0d register settings, all-zero and all-one",
             items_sent, settings_used);
    $display("registers included, with signals, erase echo, end of file and a full line store");
    if (chk_errors == 0) begin
      $display("tb_canonical_line_discipline_unit OK");
    end else begin
      $display("tb_canonical_line_discipline_unit NOT OK");
    end
    $finish;
  end

endmodule
